@@ rtl/matrix_power_engine_unit_macros.svh @@
// Assertion macros for the matrix power engine.
`ifndef MATRIX_POWER_ENGINE_UNIT_MACROS_SVH
`define MATRIX_POWER_ENGINE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define MPE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mpe assertion failed");
// checked during reset too
`define MPE_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("mpe reset assertion failed");
`else
`define MPE_ASSERT(lbl, prop)
`define MPE_ASSERT_RST(lbl, prop)
`endif

`endif

@@ rtl/mpe_pkg.sv @@
// Shared constants and helpers of the matrix power engine.
`timescale 1ns / 1ps
package mpe_pkg;

	localparam int MAX_DIM    = 8;
	localparam int DATA_WIDTH = 32;
	localparam int CELLS      = MAX_DIM * MAX_DIM;
	localparam int IDX_W      = 3;
	localparam int DIM_W      = 4;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int EXP_W      = 63;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_START = 1'b1;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col);
		return ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
	endfunction

endpackage

@@ rtl/mpe_if.sv @@
// Handshake channels of the matrix power engine: items in, results out, config.
`timescale 1ns / 1ps
interface mpe_item_if import mpe_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [IDX_W-1:0]      row_index;
	logic [IDX_W-1:0]      col_index;
	logic [DATA_WIDTH-1:0] element_value;
	logic [EXP_W-1:0]      exponent;

	modport source(output valid, cmd, row_index, col_index, element_value, exponent,
		input ready);
	modport sink(input valid, cmd, row_index, col_index, element_value, exponent,
		output ready);
endinterface

interface mpe_result_if import mpe_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [IDX_W-1:0]      out_row;
	logic [IDX_W-1:0]      out_col;
	logic [DATA_WIDTH-1:0] out_value;
	logic                  last;

	modport source(output valid, out_row, out_col, out_value, last, input ready);
	modport sink(input valid, out_row, out_col, out_value, last, output ready);
endinterface

interface mpe_cfg_if import mpe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DIM_W-1:0] dimension;

	modport source(output valid, dimension, input ready);
	modport sink(input valid, dimension, output ready);
endinterface

@@ rtl/matrix_power_engine_unit.sv @@
// Matrix power engine: square-and-multiply matrix power on one shared multiplier.
`timescale 1ns / 1ps
`include "matrix_power_engine_unit_macros.svh"
// A load word (cmd 0) writes one element of the source matrix.
// A start word (cmd 1) raises the loaded d x d matrix (d from the dimension
// register, 0 read as 1, above 8 read as 8) to the given exponent, scanning it
// from the low bit. All multiply-accumulates run on a single 32x32 multiplier
// fed from block memories, one per cycle; one matrix product is d^3 MACs, a
// d^2 copy back, a pipeline drain and a bit step. A start runs a setup walk
// over the d^2 cells, then one product per set exponent bit and one squaring
// per bit below the top one: at most 125 products. The result then leaves as
// d^2 words, row by row, each only after the previous one has been accepted,
// with last set on the final one. Input is not taken until the last result
// word has been accepted. Every element inside the used corner must be loaded
// before a start.
module matrix_power_engine_unit import mpe_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	mpe_cfg_if.sink       cfg,
	mpe_item_if.sink      item,
	mpe_result_if.source  result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_BIT,
		S_MUL,
		S_COPY,
		S_ORD,
		S_OWAIT
	} state_t;

	state_t                state_q;
	logic [DIM_W-1:0]      dim_q;
	logic [IDX_W-1:0]      dm1_q;
	logic [EXP_W-1:0]      exp_q;
	logic                  acc_done_q;
	logic                  op_acc_q;
	logic [IDX_W-1:0]      ri_q, cj_q, kk_q;
	logic                  walk_end_q;
	logic                  out_valid_q;
	logic                  v_s1, v_s2, cp_v_s1;
	logic                  first_s1, last_s1, first_s2, last_s2;
	logic [ADDR_W-1:0]     waddr_s1, waddr_s2, cp_addr_s1;

	logic [DATA_WIDTH-1:0] src_mem [CELLS];
	logic [DATA_WIDTH-1:0] bas_mem [CELLS];
	logic [DATA_WIDTH-1:0] acc_mem [CELLS];
	logic [DATA_WIDTH-1:0] scr_mem [CELLS];
	logic [DATA_WIDTH-1:0] src_rd_q, bas_rda_q, bas_rdb_q, acc_rd_q, scr_rd_q;
	logic [DATA_WIDTH-1:0] prod_s2, mac_q;

	logic                  in_acc, load_we, start;
	logic [DIM_W-1:0]      used_dim;
	logic                  walk_last, mul_last, issue_walk, issue_mul;
	logic [ADDR_W-1:0]     addr_ij, addr_ik, addr_kj, acc_raddr, acc_waddr;
	logic                  acc_we, bas_we, scr_we;
	logic [DATA_WIDTH-1:0] acc_wdata, bas_wdata, op_a, mac_sum;

	assign in_acc  = item.valid && item.ready;
	assign start   = in_acc && (item.cmd == CMD_START);
	assign load_we = in_acc && (item.cmd == CMD_LOAD)
		&& ({1'b0, item.row_index} < DIM_W'(MAX_DIM))
		&& ({1'b0, item.col_index} < DIM_W'(MAX_DIM));

	always_comb begin
		if (dim_q == '0) begin
			used_dim = DIM_W'(1);
		end else if (dim_q > DIM_W'(MAX_DIM)) begin
			used_dim = DIM_W'(MAX_DIM);
		end else begin
			used_dim = dim_q;
		end
	end

	assign walk_last  = (ri_q == dm1_q) && (cj_q == dm1_q);
	assign mul_last   = walk_last && (kk_q == dm1_q);
	assign issue_walk = ((state_q == S_INIT) || (state_q == S_COPY)) && !walk_end_q;
	assign issue_mul  = (state_q == S_MUL) && !walk_end_q;

	assign addr_ij   = cell_addr(ri_q, cj_q);
	assign addr_ik   = cell_addr(ri_q, kk_q);
	assign addr_kj   = cell_addr(kk_q, cj_q);
	assign acc_raddr = (state_q == S_MUL) ? addr_ik : addr_ij;

	// setup writes identity at issue; copy-back writes in the cycle after the scratch read
	assign acc_we    = ((state_q == S_INIT) && issue_walk)
		|| ((state_q == S_COPY) && cp_v_s1 && op_acc_q);
	assign acc_waddr = (state_q == S_INIT) ? addr_ij : cp_addr_s1;
	assign acc_wdata = (state_q == S_INIT)
		? ((ri_q == cj_q) ? DATA_WIDTH'(1) : '0) : scr_rd_q;
	assign bas_we    = cp_v_s1 && ((state_q == S_INIT) || ((state_q == S_COPY) && !op_acc_q));
	assign bas_wdata = (state_q == S_INIT) ? src_rd_q : scr_rd_q;

	assign op_a    = op_acc_q ? acc_rd_q : bas_rda_q;
	assign mac_sum = first_s2 ? prod_s2 : mac_q + prod_s2;
	assign scr_we  = v_s2 && last_s2;

	assign cfg.ready      = 1'b1;
	assign item.ready     = (state_q == S_IDLE);
	assign result.valid   = out_valid_q;
	assign result.out_row = ri_q;
	assign result.out_col = cj_q;
	assign result.out_value = acc_rd_q;
	assign result.last    = walk_last;

	always_ff @(posedge clk) begin
		if (load_we) begin
			src_mem[cell_addr(item.row_index, item.col_index)] <= item.element_value;
		end
		src_rd_q <= src_mem[addr_ij];
	end

	always_ff @(posedge clk) begin
		if (bas_we) begin
			bas_mem[cp_addr_s1] <= bas_wdata;
		end
		bas_rda_q <= bas_mem[addr_ik];
		bas_rdb_q <= bas_mem[addr_kj];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		acc_rd_q <= acc_mem[acc_raddr];
	end

	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_mem[waddr_s2] <= mac_sum;
		end
		scr_rd_q <= scr_mem[addr_ij];
	end

	// MAC datapath: read -> multiply -> accumulate
	always_ff @(posedge clk) begin
		first_s1   <= (kk_q == '0);
		last_s1    <= (kk_q == dm1_q);
		waddr_s1   <= addr_ij;
		cp_addr_s1 <= addr_ij;
		prod_s2    <= op_a * bas_rdb_q;
		first_s2   <= first_s1;
		last_s2    <= last_s1;
		waddr_s2   <= waddr_s1;
		mac_q      <= mac_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dim_q       <= DIM_W'(MAX_DIM);
			dm1_q       <= '0;
			exp_q       <= '0;
			acc_done_q  <= 1'b0;
			op_acc_q    <= 1'b0;
			ri_q        <= '0;
			cj_q        <= '0;
			kk_q        <= '0;
			walk_end_q  <= 1'b0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			cp_v_s1     <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				dim_q <= cfg.dimension;
			end
			v_s1    <= issue_mul;
			v_s2    <= v_s1;
			cp_v_s1 <= issue_walk;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						dm1_q      <= IDX_W'(used_dim - DIM_W'(1));
						exp_q      <= item.exponent;
						acc_done_q <= 1'b0;
						ri_q       <= '0;
						cj_q       <= '0;
						kk_q       <= '0;
						walk_end_q <= 1'b0;
						state_q    <= S_INIT;
					end
				end
				S_INIT, S_COPY: begin
					if (!walk_end_q) begin
						if (cj_q == dm1_q) begin
							cj_q <= '0;
							ri_q <= ri_q + IDX_W'(1);
						end else begin
							cj_q <= cj_q + IDX_W'(1);
						end
						if (walk_last) begin
							walk_end_q <= 1'b1;
						end
					end else if (!cp_v_s1) begin
						walk_end_q <= 1'b0;
						ri_q       <= '0;
						cj_q       <= '0;
						if (state_q == S_COPY) begin
							if (op_acc_q) begin
								acc_done_q <= 1'b1;
							end else begin
								exp_q      <= exp_q >> 1;
								acc_done_q <= 1'b0;
							end
						end
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					priority if (exp_q == '0) begin
						state_q <= S_ORD;
					end else if (exp_q[0] && !acc_done_q) begin
						op_acc_q <= 1'b1;
						state_q  <= S_MUL;
					end else if (exp_q == EXP_W'(1)) begin
						// final squaring would never be used
						exp_q   <= '0;
						state_q <= S_ORD;
					end else begin
						op_acc_q <= 1'b0;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					if (!walk_end_q) begin
						if (kk_q == dm1_q) begin
							kk_q <= '0;
							if (cj_q == dm1_q) begin
								cj_q <= '0;
								ri_q <= ri_q + IDX_W'(1);
							end else begin
								cj_q <= cj_q + IDX_W'(1);
							end
						end else begin
							kk_q <= kk_q + IDX_W'(1);
						end
						if (mul_last) begin
							walk_end_q <= 1'b1;
						end
					end else if (!v_s1 && !v_s2) begin
						walk_end_q <= 1'b0;
						ri_q       <= '0;
						cj_q       <= '0;
						kk_q       <= '0;
						state_q    <= S_COPY;
					end
				end
				S_ORD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OWAIT;
				end
				S_OWAIT: begin
					if (result.ready) begin
						out_valid_q <= 1'b0;
						if (walk_last) begin
							ri_q    <= '0;
							cj_q    <= '0;
							state_q <= S_IDLE;
						end else begin
							if (cj_q == dm1_q) begin
								cj_q <= '0;
								ri_q <= ri_q + IDX_W'(1);
							end else begin
								cj_q <= cj_q + IDX_W'(1);
							end
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`MPE_ASSERT(a_idle_no_result, item.ready |-> !result.valid)
	`MPE_ASSERT(a_last_frees_input, result.valid && result.ready && result.last |=> item.ready)
	`MPE_ASSERT(a_start_busy, item.valid && item.ready && item.cmd == CMD_START |=> !item.ready)
	`MPE_ASSERT(a_mac_in_mul, v_s2 |-> state_q == S_MUL)
	`MPE_ASSERT_RST(a_reset_quiet, !arst_n |-> !result.valid)

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the matrix power engine: loads, starts, result checking.
`timescale 1ns / 1ps
module tb import mpe_pkg::*; ();

	localparam int CYCLE_LIMIT    = 3_000_000;
	localparam int HOLD_CYCLES    = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 50;
	localparam int PHASE_ITEMS    = 3;
	localparam int NUM_PHASES     = 10;
	localparam int PRESSURE_PHASE = 3;
	localparam bit [DIM_W-1:0] PHASE_DIMS [NUM_PHASES] =
		'{4'd3, 4'd1, 4'd8, 4'd4, 4'd15, 4'd2, 4'd6, 4'd9, 4'd5, 4'd8};

	typedef struct packed {
		logic                  cmd;
		logic [IDX_W-1:0]      row;
		logic [IDX_W-1:0]      col;
		logic [DATA_WIDTH-1:0] value;
		logic [EXP_W-1:0]      exponent;
	} mpe_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]      row;
		logic [IDX_W-1:0]      col;
		logic [DATA_WIDTH-1:0] value;
		logic                  last;
	} result_elem_t;

	typedef bit [DATA_WIDTH-1:0] cell_array_t [CELLS];

	class mpe_scoreboard;
		cell_array_t        source_cells;
		bit [DIM_W-1:0]     dim_reg;
		result_elem_t       expected_elems [$];
		int                 mismatches;

		function new();
			foreach (source_cells[k])
				source_cells[k] = '0;
			dim_reg = DIM_W'(MAX_DIM);
			mismatches = 0;
		endfunction

		function int used_dim();
			if (dim_reg == 0)
				return 1;
			if (dim_reg > MAX_DIM)
				return MAX_DIM;
			return int'(dim_reg);
		endfunction

		function void set_dimension(bit [DIM_W-1:0] d);
			dim_reg = d;
		endfunction

		function int pending();
			return expected_elems.size();
		endfunction

		function void mat_product(input cell_array_t lhs, input cell_array_t rhs,
			input int d, output cell_array_t prod);
			bit [DATA_WIDTH-1:0] acc;
			prod = lhs;
			for (int i = 0; i < d; i++) begin
				for (int j = 0; j < d; j++) begin
					acc = '0;
					for (int k = 0; k < d; k++)
						acc += lhs[i * MAX_DIM + k] * rhs[k * MAX_DIM + j];
					prod[i * MAX_DIM + j] = acc;
				end
			end
		endfunction

		// square-and-multiply from the low exponent bit
		function void note_word(mpe_word_t w);
			cell_array_t    base;
			cell_array_t    power;
			bit [EXP_W-1:0] e;
			result_elem_t   r;
			int             d;
			if (w.cmd == CMD_LOAD) begin
				source_cells[int'(w.row) * MAX_DIM + int'(w.col)] = w.value;
				return;
			end
			d = used_dim();
			base = source_cells;
			foreach (power[k])
				power[k] = (k / MAX_DIM == k % MAX_DIM) ? 1 : 0;
			e = w.exponent;
			while (e != 0) begin
				if (e[0])
					mat_product(power, base, d, power);
				mat_product(base, base, d, base);
				e >>= 1;
			end
			for (int i = 0; i < d; i++) begin
				for (int j = 0; j < d; j++) begin
					r.row = IDX_W'(i);
					r.col = IDX_W'(j);
					r.value = power[i * MAX_DIM + j];
					r.last = (i == d - 1 && j == d - 1);
					expected_elems.push_back(r);
				end
			end
		endfunction

		function void check_result(result_elem_t got);
			result_elem_t want;
			if (expected_elems.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: row %0d col %0d value %h last %0b",
						got.row, got.col, got.value, got.last);
				return;
			end
			want = expected_elems.pop_front();
			if (got.row !== want.row || got.col !== want.col ||
				got.value !== want.value || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %0d,%0d %h last %0b, got %0d,%0d %h last %0b",
						want.row, want.col, want.value, want.last,
						got.row, got.col, got.value, got.last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mpe_cfg_if    cfg_ch();
	mpe_item_if   item_ch();
	mpe_result_if result_ch();

	matrix_power_engine_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	mpe_scoreboard sb;
	bit            loaded [CELLS];
	bit            no_idle;
	bit            hold_request;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic bit [DATA_WIDTH-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return DATA_WIDTH'($urandom_range(0, 3));
			default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	function automatic bit [EXP_W-1:0] rand_exponent();
		bit [63:0] x;
		x = {$urandom, $urandom};
		return x[EXP_W-1:0];
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_word(input mpe_word_t w);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.cmd           <= w.cmd;
		item_ch.row_index     <= w.row;
		item_ch.col_index     <= w.col;
		item_ch.element_value <= w.value;
		item_ch.exponent      <= w.exponent;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		sb.note_word(w);
		if (w.cmd == CMD_LOAD)
			loaded[int'(w.row) * MAX_DIM + int'(w.col)] = 1'b1;
		@(negedge clk);
	endtask

	task automatic send_load(input bit [IDX_W-1:0] r, input bit [IDX_W-1:0] c,
		input bit [DATA_WIDTH-1:0] v);
		mpe_word_t w;
		w.cmd = CMD_LOAD;
		w.row = r;
		w.col = c;
		w.value = v;
		w.exponent = rand_exponent();
		send_word(w);
	endtask

	// fills any unloaded cell of the used corner first
	task automatic send_start(input bit [EXP_W-1:0] e);
		mpe_word_t w;
		int        d;
		d = sb.used_dim();
		for (int i = 0; i < d; i++)
			for (int j = 0; j < d; j++)
				if (!loaded[i * MAX_DIM + j])
					send_load(IDX_W'(i), IDX_W'(j), pick_value());
		w.cmd = CMD_START;
		w.row = IDX_W'($urandom_range(0, MAX_DIM - 1));
		w.col = IDX_W'($urandom_range(0, MAX_DIM - 1));
		w.value = DATA_WIDTH'($urandom);
		w.exponent = e;
		send_word(w);
	endtask

	// only with the block idle
	task automatic write_dimension(input bit [DIM_W-1:0] d);
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.dimension <= d;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		sb.set_dimension(d);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: errors");
		$finish;
	end

	initial begin
		result_elem_t got;
		int           gap;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				gap = draw_gap();
				if (gap > 0) begin
					result_ch.ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			got.row = result_ch.out_row;
			got.col = result_ch.out_col;
			got.value = result_ch.out_value;
			got.last = result_ch.last;
			sb.check_result(got);
			@(negedge clk);
		end
	end

	initial begin
		bit [EXP_W-1:0] e;
		int             sent;
		int             starts;
		int             d;
		sb = new();
		foreach (loaded[k])
			loaded[k] = 1'b0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.dimension = DIM_W'(MAX_DIM);
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_LOAD;
		item_ch.row_index = '0;
		item_ch.col_index = '0;
		item_ch.element_value = '0;
		item_ch.exponent = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: reset dimension, corner extremes
		send_load(3'd0, 3'd0, '1);
		send_load(3'd0, 3'd7, '0);
		send_load(3'd7, 3'd0, 32'h8000_0000);
		send_load(3'd7, 3'd7, 32'd1);
		send_start('0);
		send_start(EXP_W'(1));

		write_dimension(4'd2);
		send_load(3'd0, 3'd0, '1);
		send_load(3'd0, 3'd1, '0);
		send_load(3'd1, 3'd0, 32'd1);
		send_load(3'd1, 3'd1, '1);
		send_start('1);
		send_start(EXP_W'(1) << (EXP_W - 1));
		// outside the used corner: stored, not used
		send_load(3'd5, 3'd6, 32'hdead_beef);
		send_start(EXP_W'(3));

		// dimension zero reads as one
		write_dimension(4'd0);
		send_start(EXP_W'(5));

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_dimension(PHASE_DIMS[p]);
			no_idle = ($urandom_range(0, 3) == 0);
			if (p == PRESSURE_PHASE)
				hold_request = 1'b1;
			d = sb.used_dim();
			sent = 0;
			starts = 0;
			while (sent < PHASE_ITEMS || starts == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 2))
						0: e = EXP_W'($urandom_range(0, 15));
						1: e = EXP_W'($urandom_range(0, 65535));
						default: e = rand_exponent();
					endcase
					if (d > 4)
						e &= (EXP_W'(1) << $urandom_range(1, 12)) - 1;
					send_start(e);
					starts++;
				end else if ($urandom_range(0, 4) == 0) begin
					send_load(IDX_W'($urandom_range(0, MAX_DIM - 1)),
						IDX_W'($urandom_range(0, MAX_DIM - 1)), pick_value());
				end else begin
					send_load(IDX_W'($urandom_range(0, d - 1)),
						IDX_W'($urandom_range(0, d - 1)), pick_value());
				end
				sent++;
			end
		end

		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/mpe_pkg.sv
rtl/mpe_if.sv
rtl/matrix_power_engine_unit.sv
dv/tb.sv
